// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the peak detector
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/pdms_pkg.sv =====
// ----------------------------------------------------------------------------
// pdms_pkg
// types and constants shared by the peak detector modules
// ----------------------------------------------------------------------------
package pdms_pkg;

  // sample and frame sizing
  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_LEN      = 4096;
  localparam int IDX_BITS     = $clog2(MAX_LEN + 1);
  localparam int POS_BITS     = 12;
  localparam int MIN_SEP_BITS = 12;

  // configuration port
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 16;

  // event queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [POS_BITS-1:0]           pos_t;
  typedef logic [IDX_BITS-1:0]           idx_t;
  typedef logic [MIN_SEP_BITS-1:0]       min_sep_t;
  typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0]      cfg_data_t;
  typedef logic [QPTR_BITS-1:0]          qptr_t;
  typedef logic [QPTR_BITS:0]            qcnt_t;

  // register indexes
  localparam cfg_idx_t CFG_THRESHOLD = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_MIN_SEP   = cfg_idx_t'(1);

  // register reset values
  localparam sample_t  THRESHOLD_RESET = sample_t'(0);
  localparam min_sep_t MIN_SEP_RESET   = min_sep_t'(25);

  // results caused by one input item
  typedef struct packed {
    logic    emit_valid;   // a replaced pending peak leaves
    pos_t    emit_pos;
    sample_t emit_value;
    logic    eof_valid;    // frame end record present
    logic    eof_peak;     // frame end carries a peak
    pos_t    eof_pos;
    sample_t eof_value;
  } event_t;

endpackage

// ===== hdl/pdms_ifs.sv =====
// ----------------------------------------------------------------------------
// pdms interfaces
// valid/ready channels for samples, results and configuration writes
// ----------------------------------------------------------------------------
interface pdms_in_if;
  import pdms_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    end_of_frame;
  modport source (output valid, sample, end_of_frame, input ready);
  modport sink (input valid, sample, end_of_frame, output ready);
endinterface

interface pdms_out_if;
  import pdms_pkg::*;
  logic    valid;
  logic    ready;
  pos_t    position;
  sample_t peak_value;
  logic    peak_valid;
  logic    frame_done;
  logic    last_of_run;
  modport source (output valid, position, peak_value, peak_valid, frame_done,
                  last_of_run, input ready);
  modport sink (input valid, position, peak_value, peak_valid, frame_done,
                last_of_run, output ready);
endinterface

interface pdms_cfg_if;
  import pdms_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/pdms_front.sv =====
// ----------------------------------------------------------------------------
// pdms_front
// accepts samples, finds candidates, merges them into the pending peak
// and pushes one event per item that causes results
// ----------------------------------------------------------------------------
module pdms_front (
  input  logic             clk,
  input  logic             rst_n,
  pdms_in_if.sink          in_ch,
  pdms_cfg_if.sink         cfg_ch,
  input  logic             q_full,
  output logic             q_push,
  output pdms_pkg::event_t q_data
);
  import pdms_pkg::*;

  sample_t  thr_r, thr_nxt;
  min_sep_t min_sep_r, min_sep_nxt;
  sample_t  prev_r, prev_nxt;
  sample_t  pprev_r, pprev_nxt;
  idx_t     idx_r, idx_nxt;
  logic     pend_v_r, pend_v_nxt;
  pos_t     pend_pos_r, pend_pos_nxt;
  sample_t  pend_val_r, pend_val_nxt;

  logic     accept;
  logic     cand;
  logic     close;
  pos_t     cand_pos;
  pos_t     pos_gap;
  logic     upd_v;
  pos_t     upd_pos;
  sample_t  upd_val;
  event_t   ev;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  // candidate test on the middle sample of the window
  assign cand = (idx_r >= idx_t'(2)) && (prev_r > pprev_r) &&
                (prev_r > in_ch.sample) && (prev_r > thr_r);
  assign cand_pos = pos_t'(idx_r - idx_t'(1));
  assign pos_gap  = cand_pos - pend_pos_r;
  assign close    = pend_v_r && (min_sep_t'(pos_gap) < min_sep_r);

  // merge or replace the pending peak
  always_comb begin
    upd_v          = pend_v_r;
    upd_pos        = pend_pos_r;
    upd_val        = pend_val_r;
    ev             = '0;
    ev.emit_pos    = pend_pos_r;
    ev.emit_value  = pend_val_r;
    if (cand) begin
      if (close) begin
        if (!(pend_val_r > prev_r)) begin
          upd_pos = cand_pos;
          upd_val = prev_r;
        end
      end else begin
        ev.emit_valid = pend_v_r;
        upd_v         = 1'b1;
        upd_pos       = cand_pos;
        upd_val       = prev_r;
      end
    end
    // frame end record
    ev.eof_valid = in_ch.end_of_frame;
    ev.eof_peak  = upd_v;
    ev.eof_pos   = upd_v ? upd_pos : '0;
    ev.eof_value = upd_v ? upd_val : '0;
  end

  assign q_push = accept && (ev.emit_valid || ev.eof_valid);
  assign q_data = ev;

  // next state for frame and config registers
  always_comb begin
    thr_nxt      = thr_r;
    min_sep_nxt  = min_sep_r;
    prev_nxt     = prev_r;
    pprev_nxt    = pprev_r;
    idx_nxt      = idx_r;
    pend_v_nxt   = pend_v_r;
    pend_pos_nxt = pend_pos_r;
    pend_val_nxt = pend_val_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_THRESHOLD: thr_nxt = sample_t'(cfg_ch.data[SAMPLE_BITS-1:0]);
        CFG_MIN_SEP:   min_sep_nxt = cfg_ch.data[MIN_SEP_BITS-1:0];
        default: ;
      endcase
    end
    if (accept) begin
      if (in_ch.end_of_frame) begin
        prev_nxt     = '0;
        pprev_nxt    = '0;
        idx_nxt      = '0;
        pend_v_nxt   = 1'b0;
        pend_pos_nxt = '0;
        pend_val_nxt = '0;
      end else begin
        pprev_nxt    = prev_r;
        prev_nxt     = in_ch.sample;
        if (idx_r != idx_t'(MAX_LEN)) begin
          idx_nxt = idx_r + idx_t'(1);
        end
        pend_v_nxt   = upd_v;
        pend_pos_nxt = upd_pos;
        pend_val_nxt = upd_val;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THRESHOLD_RESET;
      min_sep_r  <= MIN_SEP_RESET;
      prev_r     <= '0;
      pprev_r    <= '0;
      idx_r      <= '0;
      pend_v_r   <= 1'b0;
      pend_pos_r <= '0;
      pend_val_r <= '0;
    end else begin
      thr_r      <= thr_nxt;
      min_sep_r  <= min_sep_nxt;
      prev_r     <= prev_nxt;
      pprev_r    <= pprev_nxt;
      idx_r      <= idx_nxt;
      pend_v_r   <= pend_v_nxt;
      pend_pos_r <= pend_pos_nxt;
      pend_val_r <= pend_val_nxt;
    end
  end

endmodule

// ===== hdl/pdms_queue.sv =====
// ----------------------------------------------------------------------------
// pdms_queue
// small event queue that decouples the front from the result stage
// ----------------------------------------------------------------------------
module pdms_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pdms_pkg::event_t push_data,
  input  logic             pop,
  output pdms_pkg::event_t head,
  output logic             full,
  output logic             empty
);
  import pdms_pkg::*;

  event_t mem_r [QDEPTH];
  qptr_t  wr_ptr_r, wr_ptr_nxt;
  qptr_t  rd_ptr_r, rd_ptr_nxt;
  qcnt_t  cnt_r, cnt_nxt;
  logic   do_push;
  logic   do_pop;

  assign full    = (cnt_r == qcnt_t'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == qptr_t'(QDEPTH - 1)) ? '0 : wr_ptr_r + qptr_t'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == qptr_t'(QDEPTH - 1)) ? '0 : rd_ptr_r + qptr_t'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + qcnt_t'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - qcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/pdms_back.sv =====
// ----------------------------------------------------------------------------
// pdms_back
// unpacks queued events into result transfers through an output register
// ----------------------------------------------------------------------------
module pdms_back (
  input  logic             clk,
  input  logic             rst_n,
  input  pdms_pkg::event_t head,
  input  logic             q_empty,
  output logic             q_pop,
  pdms_out_if.source       out_ch
);
  import pdms_pkg::*;

  logic    out_v_r, out_v_nxt;
  logic    second_r, second_nxt;
  pos_t    pos_r, pos_nxt;
  sample_t val_r, val_nxt;
  logic    pv_r, pv_nxt;
  logic    done_r, done_nxt;
  logic    last_r, last_nxt;
  logic    load;
  logic    take_eof;

  assign load = !out_v_r || out_ch.ready;

  // choose the next record from the head event
  always_comb begin
    q_pop      = 1'b0;
    second_nxt = second_r;
    out_v_nxt  = out_v_r;
    take_eof   = 1'b1;
    if (load) begin
      out_v_nxt = !q_empty;
      if (!q_empty) begin
        if (!second_r && head.emit_valid) begin
          take_eof = 1'b0;
          if (head.eof_valid) begin
            second_nxt = 1'b1;
          end else begin
            q_pop = 1'b1;
          end
        end else begin
          second_nxt = 1'b0;
          q_pop      = 1'b1;
        end
      end
    end
  end

  // result fields of the chosen record
  always_comb begin
    if (take_eof) begin
      pos_nxt  = head.eof_pos;
      val_nxt  = head.eof_value;
      pv_nxt   = head.eof_peak;
      done_nxt = 1'b1;
      last_nxt = 1'b1;
    end else begin
      pos_nxt  = head.emit_pos;
      val_nxt  = head.emit_value;
      pv_nxt   = 1'b1;
      done_nxt = 1'b0;
      last_nxt = !head.eof_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      second_r <= second_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      pos_r  <= pos_nxt;
      val_r  <= val_nxt;
      pv_r   <= pv_nxt;
      done_r <= done_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.position    = pos_r;
  assign out_ch.peak_value  = val_r;
  assign out_ch.peak_valid  = pv_r;
  assign out_ch.frame_done  = done_r;
  assign out_ch.last_of_run = last_r;

endmodule

// ===== hdl/peak_detect_min_separation.sv =====
// ----------------------------------------------------------------------------
// peak_detect_min_separation
// Streaming peak finder: takes one signed sample per cycle unless the event
// queue is full, and reports strict local maxima above the threshold, merging
// peaks closer than min_separation (larger kept, later kept on a tie). A
// sample that both releases a pending peak and ends the frame yields two
// result transfers. The front keeps taking samples while results wait,
// until the four-entry event queue between front and result stage fills;
// a result passes through that queue and then the output register.
// Configuration writes are always ready and take effect in the next cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module peak_detect_min_separation (
  input  logic       clk,
  input  logic       rst_n,
  pdms_in_if.sink    in_ch,
  pdms_out_if.source out_ch,
  pdms_cfg_if.sink   cfg_ch
);
  import pdms_pkg::*;

  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  event_t q_in;
  event_t q_head;

  // sample classification and pending peak
  pdms_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // event queue
  pdms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // result stage
  pdms_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // checks
  `ASSERT_SAME(a_no_overflow, clk, rst_n, q_push, !q_full)
  `ASSERT_SAME(a_empty_end, clk, rst_n, out_ch.valid && !out_ch.peak_valid,
               out_ch.frame_done && out_ch.last_of_run && out_ch.position == '0)
  `ASSERT_SAME(a_done_last, clk, rst_n, out_ch.valid && out_ch.frame_done,
               out_ch.last_of_run)
  `ASSERT_NEXT(a_pop_nonempty, clk, rst_n, q_pop && q_empty, 1'b0)

endmodule
